>>> rtl/cmav_pkg.sv
// ----------------------------------------------------------------------------
// cmav_pkg
// Shared codes, register indexes and control bundles of the crop max
// accumulate volume unit.
// ----------------------------------------------------------------------------
package cmav_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [1:0]                kind_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [8:0]                dim_type;

   localparam kind_type KIND_MERGE = 2'd0;
   localparam kind_type KIND_CLEAR = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;

   localparam csr_index_type REG_VOLUME_WIDTH  = 4'd0;
   localparam csr_index_type REG_VOLUME_HEIGHT = 4'd1;
   localparam csr_index_type REG_CROP_FIRST_X  = 4'd2;
   localparam csr_index_type REG_CROP_FIRST_Y  = 4'd3;
   localparam csr_index_type REG_CROP_FIRST_Z  = 4'd4;
   localparam csr_index_type REG_CROP_SIZE_X   = 4'd5;
   localparam csr_index_type REG_CROP_SIZE_Y   = 4'd6;
   localparam csr_index_type REG_CROP_SIZE_Z   = 4'd7;

   localparam dim_type VOLUME_DIM_RESET = 9'd256;
   localparam dim_type CROP_SIZE_RESET  = 9'd1;

   typedef struct packed {
      logic start;
      logic direct;
      logic step1;
      logic step2;
   } addr_ctl_type;

   typedef struct packed {
      logic advance;
      logic restart;
   } walk_ctl_type;

endpackage

>>> rtl/cmav_ifs.sv
// ----------------------------------------------------------------------------
// cmav channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmav_req_if;
   logic                    valid;
   logic                    ready;
   cmav_pkg::kind_type      kind;
   logic signed [15:0]      sample_value;
   logic [15:0]             read_address;

   modport source (output valid, kind, sample_value, read_address, input ready);
   modport sink   (input valid, kind, sample_value, read_address, output ready);
endinterface

interface cmav_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [15:0]             entry_address;
   logic signed [15:0]      entry_value;
   logic                    last_of_crop;
   logic                    out_of_range;

   modport source (output valid, entry_address, entry_value, last_of_crop, out_of_range,
                   input ready);
   modport sink   (input valid, entry_address, entry_value, last_of_crop, out_of_range,
                   output ready);
endinterface

interface cmav_csr_if;
   logic                            valid;
   logic                            ready;
   cmav_pkg::csr_index_type         index;
   logic [cmav_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/cmav_store.sv
// ----------------------------------------------------------------------------
// cmav_store
// Volume sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmav_store #(
   parameter int DEPTH     = 65536,
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cmav_regs.sv
// ----------------------------------------------------------------------------
// cmav_regs
// Crop and volume registers, and the raster walk over the crop box.
// ----------------------------------------------------------------------------
module cmav_regs #(
   parameter int AXIS_MAX  = 256,
   parameter int WALK_BITS = 8,
   parameter int POS_BITS  = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   cmav_csr_if.sink               csr,
   input  cmav_pkg::walk_ctl_type walk_ctl,
   output cmav_pkg::dim_type      vol_width,
   output cmav_pkg::dim_type      vol_height,
   output logic [POS_BITS-1:0]    pos_x,
   output logic [POS_BITS-1:0]    pos_y,
   output logic [POS_BITS-1:0]    pos_z,
   output logic                   last_sample
);

   localparam int CMP_BITS = (WALK_BITS + 1 > 9) ? WALK_BITS + 1 : 9;

   cmav_pkg::dim_type    vol_width_ff, vol_height_ff;
   logic [7:0]           first_x_ff, first_y_ff, first_z_ff;
   cmav_pkg::dim_type    size_x_ff, size_y_ff, size_z_ff;
   logic [WALK_BITS-1:0] walk_x_ff, walk_y_ff, walk_z_ff;
   logic [WALK_BITS-1:0] walk_x_in, walk_y_in, walk_z_in;
   logic [CMP_BITS-1:0]  lim_x, lim_y, lim_z;
   logic                 wrap_x, wrap_y, wrap_z;

   function automatic logic [CMP_BITS-1:0] clamp_size(input cmav_pkg::dim_type s);
      logic [CMP_BITS-1:0] v;
      v = CMP_BITS'(s);
      if (s == 9'd0) begin
         v = CMP_BITS'(1);
      end else if (v > CMP_BITS'(AXIS_MAX)) begin
         v = CMP_BITS'(AXIS_MAX);
      end
      return v;
   endfunction

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_width_ff  <= cmav_pkg::VOLUME_DIM_RESET;
         vol_height_ff <= cmav_pkg::VOLUME_DIM_RESET;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         first_z_ff    <= '0;
         size_x_ff     <= cmav_pkg::CROP_SIZE_RESET;
         size_y_ff     <= cmav_pkg::CROP_SIZE_RESET;
         size_z_ff     <= cmav_pkg::CROP_SIZE_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            cmav_pkg::REG_VOLUME_WIDTH:  vol_width_ff  <= csr.data[8:0];
            cmav_pkg::REG_VOLUME_HEIGHT: vol_height_ff <= csr.data[8:0];
            cmav_pkg::REG_CROP_FIRST_X:  first_x_ff    <= csr.data[7:0];
            cmav_pkg::REG_CROP_FIRST_Y:  first_y_ff    <= csr.data[7:0];
            cmav_pkg::REG_CROP_FIRST_Z:  first_z_ff    <= csr.data[7:0];
            cmav_pkg::REG_CROP_SIZE_X:   size_x_ff     <= csr.data[8:0];
            cmav_pkg::REG_CROP_SIZE_Y:   size_y_ff     <= csr.data[8:0];
            cmav_pkg::REG_CROP_SIZE_Z:   size_z_ff     <= csr.data[8:0];
            default: ;
         endcase
      end
   end

   assign lim_x = clamp_size(size_x_ff);
   assign lim_y = clamp_size(size_y_ff);
   assign lim_z = clamp_size(size_z_ff);

   // a position at or past a shrunken end wraps on the next advance
   assign wrap_x = (CMP_BITS'(walk_x_ff) + CMP_BITS'(1)) >= lim_x;
   assign wrap_y = (CMP_BITS'(walk_y_ff) + CMP_BITS'(1)) >= lim_y;
   assign wrap_z = (CMP_BITS'(walk_z_ff) + CMP_BITS'(1)) >= lim_z;
   assign last_sample = wrap_x && wrap_y && wrap_z;

   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      walk_z_in = walk_z_ff;
      if (walk_ctl.restart) begin
         walk_x_in = '0;
         walk_y_in = '0;
         walk_z_in = '0;
      end else if (walk_ctl.advance) begin
         if (!wrap_x) begin
            walk_x_in = walk_x_ff + WALK_BITS'(1);
         end else begin
            walk_x_in = '0;
            if (!wrap_y) begin
               walk_y_in = walk_y_ff + WALK_BITS'(1);
            end else begin
               walk_y_in = '0;
               if (!wrap_z) begin
                  walk_z_in = walk_z_ff + WALK_BITS'(1);
               end else begin
                  walk_z_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         walk_z_ff <= '0;
      end else begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         walk_z_ff <= walk_z_in;
      end
   end

   assign vol_width  = vol_width_ff;
   assign vol_height = vol_height_ff;
   assign pos_x = POS_BITS'(first_x_ff) + POS_BITS'(walk_x_ff);
   assign pos_y = POS_BITS'(first_y_ff) + POS_BITS'(walk_y_ff);
   assign pos_z = POS_BITS'(first_z_ff) + POS_BITS'(walk_z_ff);

endmodule

>>> rtl/cmav_addr.sv
// ----------------------------------------------------------------------------
// cmav_addr
// Two-stage volume address unit: (z * height + y) * width + x, or a direct address.
// ----------------------------------------------------------------------------
module cmav_addr #(
   parameter int POS_BITS = 9
) (
   input  logic                   clock,
   input  cmav_pkg::addr_ctl_type ctl,
   input  logic [POS_BITS-1:0]    pos_x,
   input  logic [POS_BITS-1:0]    pos_y,
   input  logic [POS_BITS-1:0]    pos_z,
   input  cmav_pkg::dim_type      vol_width,
   input  cmav_pkg::dim_type      vol_height,
   input  logic [15:0]            direct_address,
   output logic [POS_BITS+19:0]   full_address
);

   localparam int T1_BITS   = POS_BITS + 10;
   localparam int FULL_BITS = T1_BITS + 10;

   logic [POS_BITS-1:0]  px_ff, py_ff, pz_ff;
   cmav_pkg::dim_type    w_ff, h_ff;
   logic [POS_BITS+8:0]  prod1;
   logic [T1_BITS+8:0]   prod2;
   logic [T1_BITS-1:0]   t1_ff;
   logic [FULL_BITS-1:0] full_ff;

   assign prod1 = pz_ff * h_ff;
   assign prod2 = t1_ff * w_ff;

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         px_ff <= pos_x;
         py_ff <= pos_y;
         pz_ff <= pos_z;
         w_ff  <= vol_width;
         h_ff  <= vol_height;
      end
      if (ctl.step1) begin
         t1_ff <= T1_BITS'(prod1) + T1_BITS'(py_ff);
      end
      if (ctl.start && ctl.direct) begin
         full_ff <= FULL_BITS'(direct_address);
      end else if (ctl.step2) begin
         full_ff <= FULL_BITS'(prod2) + FULL_BITS'(px_ff);
      end
   end

   assign full_address = full_ff;

endmodule

>>> rtl/crop_max_accumulate_volume_unit.sv
// ----------------------------------------------------------------------------
// crop_max_accumulate_volume_unit
// Maximum-intensity accumulation of a cropped box into a volume memory.
// ----------------------------------------------------------------------------
// Items are handled one at a time. From accept until its result sits in the
// output register, a merge sample passes two multiply stages for the volume
// address, one memory read, and a compare and write back that waits until
// the output register is free. A read skips the multiply stages. The next
// item is accepted as soon as the result is registered, even while it waits
// on rsp. After reset, and after every clear item, the unit sweeps the
// memory one entry per cycle and takes no item meanwhile; register writes
// are always taken. A clear answers once its sweep is done.
module crop_max_accumulate_volume_unit #(
   parameter int STORE_ENTRIES = 65536,
   parameter int SAMPLE_BITS   = 16,
   parameter int AXIS_MAX      = 256
) (
   input  logic       clock,
   input  logic       reset,
   cmav_req_if.sink   req,
   cmav_rsp_if.source rsp,
   cmav_csr_if.sink   csr
);

   localparam int ADDR_BITS = $clog2(STORE_ENTRIES);
   localparam int WALK_BITS = $clog2(AXIS_MAX);
   localparam int POS_BITS  = ((WALK_BITS > 8) ? WALK_BITS : 8) + 1;
   localparam int FULL_BITS = POS_BITS + 20;
   localparam int EXT_BITS  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ADDR1  = 3'd2;
   localparam logic [2:0] ST_ADDR2  = 3'd3;
   localparam logic [2:0] ST_LOOK   = 3'd4;
   localparam logic [2:0] ST_MERGE  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [ADDR_BITS-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                          clr_reply_ff, clr_reply_in;
   logic                          is_merge_ff, is_merge_in;
   logic                          last_ff, last_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_address_ff, rsp_address_in;
   logic [15:0]                   rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_oor_ff, rsp_oor_in;

   cmav_pkg::addr_ctl_type        addr_ctl;
   cmav_pkg::walk_ctl_type        walk_ctl;
   cmav_pkg::dim_type             vol_width, vol_height;
   logic [POS_BITS-1:0]           pos_x, pos_y, pos_z;
   logic                          last_sample;
   logic [FULL_BITS-1:0]          full_address;

   logic                          accept, slot_free, oor, greater;
   logic                          wr_en, rd_en;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic [SAMPLE_BITS-1:0]        wr_data, rd_data;
   logic signed [SAMPLE_BITS-1:0] cur, merged, value_sel;
   logic signed [EXT_BITS-1:0]    value_ext;

   cmav_regs #(
      .AXIS_MAX  (AXIS_MAX),
      .WALK_BITS (WALK_BITS),
      .POS_BITS  (POS_BITS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .walk_ctl    (walk_ctl),
      .vol_width   (vol_width),
      .vol_height  (vol_height),
      .pos_x       (pos_x),
      .pos_y       (pos_y),
      .pos_z       (pos_z),
      .last_sample (last_sample)
   );

   cmav_addr #(
      .POS_BITS (POS_BITS)
   ) u_addr (
      .clock          (clock),
      .ctl            (addr_ctl),
      .pos_x          (pos_x),
      .pos_y          (pos_y),
      .pos_z          (pos_z),
      .vol_width      (vol_width),
      .vol_height     (vol_height),
      .direct_address (req.read_address),
      .full_address   (full_address)
   );

   cmav_store #(
      .DEPTH     (STORE_ENTRIES),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (full_address[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign accept    = req.valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign oor       = full_address >= FULL_BITS'(STORE_ENTRIES);

   assign cur       = $signed(rd_data);
   assign greater   = sample_ff > cur;
   assign merged    = greater ? sample_ff : cur;
   assign value_sel = oor ? '0 : (is_merge_ff ? merged : cur);
   assign value_ext = EXT_BITS'(value_sel);

   assign addr_ctl.start  = accept && ((req.kind == cmav_pkg::KIND_MERGE) ||
                                       (req.kind == cmav_pkg::KIND_READ));
   assign addr_ctl.direct = req.kind == cmav_pkg::KIND_READ;
   assign addr_ctl.step1  = state_ff == ST_ADDR1;
   assign addr_ctl.step2  = state_ff == ST_ADDR2;

   assign walk_ctl.advance = accept && (req.kind == cmav_pkg::KIND_MERGE);
   assign walk_ctl.restart = accept && (req.kind == cmav_pkg::KIND_CLEAR);

   assign rd_en = (state_ff == ST_LOOK) && !oor;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_MERGE) && slot_free && is_merge_ff && !oor && greater;
         wr_addr = full_address[ADDR_BITS-1:0];
         wr_data = sample_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      clr_reply_in   = clr_reply_ff;
      is_merge_in    = is_merge_ff;
      last_in        = last_ff;
      sample_in      = sample_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_address_in = rsp_address_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_oor_in     = rsp_oor_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_BITS'(1);
            if (clr_cnt_ff == ADDR_BITS'(STORE_ENTRIES - 1)) begin
               clr_cnt_in = '0;
               state_in   = clr_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_merge_in = req.kind == cmav_pkg::KIND_MERGE;
               last_in     = last_sample;
               sample_in   = SAMPLE_BITS'(EXT_BITS'($unsigned(req.sample_value)));
               case (req.kind)
                  cmav_pkg::KIND_MERGE: state_in = ST_ADDR1;
                  cmav_pkg::KIND_READ:  state_in = ST_LOOK;
                  cmav_pkg::KIND_CLEAR: begin
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_ADDR1: state_in = ST_ADDR2;
         ST_ADDR2: state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_MERGE;
         ST_MERGE: begin
            // hold until the output register can take the beat
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = oor ? 16'd0 : full_address[15:0];
               rsp_value_in   = value_ext[15:0];
               rsp_last_in    = is_merge_ff && last_ff;
               rsp_oor_in     = oor;
               state_in       = ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = '0;
               rsp_value_in   = '0;
               rsp_last_in    = 1'b0;
               rsp_oor_in     = 1'b0;
               clr_reply_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_merge_ff    <= is_merge_in;
      last_ff        <= last_in;
      sample_ff      <= sample_in;
      rsp_address_ff <= rsp_address_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   assign req.ready         = state_ff == ST_IDLE;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.entry_address = rsp_address_ff;
   assign rsp.entry_value   = $signed(rsp_value_ff);
   assign rsp.last_of_crop  = rsp_last_ff;
   assign rsp.out_of_range  = rsp_oor_ff;

endmodule

>>> rtl/cmav_check.sv
// ----------------------------------------------------------------------------
// cmav_check
// Port-level checks of the crop max accumulate volume unit, bound to the top.
// ----------------------------------------------------------------------------
module cmav_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_entry_address,
   input logic [15:0] rsp_entry_value,
   input logic        rsp_out_of_range
);

   logic [1:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // the memory sweep after reset blocks requests
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an accepted request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> pending_ff != 2'd2)
      else $error("request accepted while another is still in flight");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_entry_address == 16'd0 &&
                                       rsp_entry_value == 16'd0)
      else $error("out-of-range response carries address or value");

endmodule

bind crop_max_accumulate_volume_unit cmav_check u_cmav_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_entry_address (rsp.entry_address),
   .rsp_entry_value   (rsp.entry_value),
   .rsp_out_of_range  (rsp.out_of_range)
);
